FILE: hdl/vrm_pkg.sv
// Shared types and constants for the voxel ray march hit test unit.
package vrm_pkg;

  localparam int unsigned CfgAw = 5;

  localparam int unsigned XSize = 64;
  localparam int unsigned YSize = 64;
  localparam int unsigned ZSize = 64;

  localparam logic [2:0] RegEyeX  = 3'd0;
  localparam logic [2:0] RegEyeY  = 3'd1;
  localparam logic [2:0] RegEyeZ  = 3'd2;
  localparam logic [2:0] RegFocal = 3'd3;
  localparam logic [2:0] RegSteps = 3'd4;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdCast  = 1'b1;

  localparam int unsigned MagBits = 24;

  typedef enum logic [7:0] {
    StClear = 8'b0000_0001,
    StIdle  = 8'b0000_0010,
    StLen   = 8'b0000_0100,
    StMag   = 8'b0000_1000,
    StMarch = 8'b0001_0000,
    StRead  = 8'b0010_0000,
    StTest  = 8'b0100_0000,
    StDone  = 8'b1000_0000
  } state_e;

endpackage

FILE: hdl/vrm_mag_unit.sv
// Bit-serial exact step magnitude: largest m with 100*m*m*len <= c*c*2^(2F).
module vrm_mag_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [9:0]  ca_i,
  input  logic [20:0] len_i,
  output logic        done_o,
  output logic [vrm_pkg::MagBits-1:0] mag_o
);
  import vrm_pkg::*;

  localparam int unsigned BitW = $clog2(MagBits);
  localparam int unsigned RhsW = 20 + 2 * FRAC_BITS;
  localparam int unsigned LhsW = 2 * MagBits + 28;

  logic [MagBits-1:0] m_q, m_d;
  logic [BitW-1:0]    bit_q, bit_d;
  logic               run_q, run_d;
  logic [RhsW-1:0]    rem_q, rem_d;
  logic [LhsW-1:0]    acc_q, acc_d;
  logic [LhsW-1:0]    trial;
  logic [RhsW-1:0]    rhs;
  logic [27:0]        len100;
  logic [BitW:0]      sh1;
  logic [BitW:0]      sh2;

  assign len100 = {7'd0, len_i} * 28'd100;
  assign rhs    = RhsW'({10'd0, ca_i} * {10'd0, ca_i}) << (2 * FRAC_BITS);
  assign sh1    = {1'b0, bit_q} + 1'b1;
  assign sh2    = {bit_q, 1'b0};
  assign trial  = (acc_q << sh1) + (LhsW'(len100) << sh2);

  always_comb begin
    m_d   = m_q;
    bit_d = bit_q;
    run_d = run_q;
    rem_d = rem_q;
    acc_d = acc_q;
    if (start_i) begin
      m_d   = '0;
      bit_d = BitW'(MagBits - 1);
      run_d = (len_i != '0);
      rem_d = rhs;
      acc_d = '0;
    end else if (run_q) begin
      if (trial <= LhsW'(rem_q)) begin
        m_d   = m_q | (MagBits'(1) << bit_q);
        rem_d = rem_q - RhsW'(trial);
        acc_d = acc_q + (LhsW'(len100) << bit_q);
      end
      if (bit_q == '0) run_d = 1'b0;
      else bit_d = bit_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    bit_q <= bit_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign done_o = !run_q && !start_i;
  assign mag_o  = m_q;
endmodule

FILE: hdl/voxel_ray_march_hit_test_unit.sv
// Top level of the voxel ray march hit test unit.
// Usage: an item is taken when start_i is high and busy_o is low. cmd_i = 0
// writes one cell (solid_i) at cell_x/y/z_i and gives no result; cmd_i = 1
// casts a ray with offset pix_w_i, pix_h_i and gives one result: hit_o is
// valid while valid_o is high for exactly one cycle.
// A write goes to the grid memory in the cycle after it is taken; busy_o
// stays low, so the next item can follow at once. A cast holds busy_o while
// it forms the squared length (StLen), runs the bit-serial magnitude unit
// once per axis (StMag), then visits each sample point in the states
// StMarch, StRead and StTest on the grid memory's single read port, up to
// max_steps points, ends the march in StMarch (skipped on a hit) and reports
// in StDone, with valid_o in the cycle after StDone.
// After reset the block clears the grid one cell a cycle, all 262144 cells
// of the 64 x 64 x 64 grid, and holds busy_o high;
// APB writes to eye_x, eye_y, eye_z, focal_distance and max_steps
// (byte addresses 0,4,8,12,16) are taken at all times and hold.
// The receiver cannot stall: the result is shown once and dropped.
module voxel_ray_march_hit_test_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    cmd_i,
  input  logic [5:0]              cell_x_i,
  input  logic [5:0]              cell_y_i,
  input  logic [5:0]              cell_z_i,
  input  logic                    solid_i,
  input  logic signed [9:0]       pix_w_i,
  input  logic signed [9:0]       pix_h_i,
  output logic                    valid_o,
  output logic                    hit_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [vrm_pkg::CfgAw-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import vrm_pkg::*;

  localparam int unsigned XW    = $clog2(XSize);
  localparam int unsigned YW    = $clog2(YSize);
  localparam int unsigned ZW    = $clog2(ZSize);
  localparam int unsigned Depth = XSize * YSize * ZSize;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned PW    = 10 + FRAC_BITS + 12;

  logic [5:0] eye_x_q, eye_y_q, eye_z_q;
  logic [9:0] focal_q, steps_q;
  logic       cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_x_q <= 6'd10;
      eye_y_q <= 6'd10;
      eye_z_q <= 6'd10;
      focal_q <= 10'd100;
      steps_q <= 10'd250;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (paddr[CfgAw-1:2])
        RegEyeX:  eye_x_q <= pwdata[5:0];
        RegEyeY:  eye_y_q <= pwdata[5:0];
        RegEyeZ:  eye_z_q <= pwdata[5:0];
        RegFocal: focal_q <= pwdata[9:0];
        RegSteps: steps_q <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CfgAw-1:2])
      RegEyeX:  prdata = {26'd0, eye_x_q};
      RegEyeY:  prdata = {26'd0, eye_y_q};
      RegEyeZ:  prdata = {26'd0, eye_z_q};
      RegFocal: prdata = {22'd0, focal_q};
      RegSteps: prdata = {22'd0, steps_q};
      default:  prdata = '0;
    endcase
  end

  // grid memory
  logic          mem [Depth];
  logic          mem_we, mem_wd, mem_rd_q;
  logic [AW-1:0] mem_wa, mem_ra;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_q <= mem[mem_ra];
  end

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [1:0]    idx_q, idx_d;
  logic [20:0]   len_q, len_d;
  logic [9:0]    w_q, h_q, f_q;
  logic          wneg_q, hneg_q;
  logic signed [PW-1:0] px_q, py_q, pz_q, px_d, py_d, pz_d;
  logic signed [PW-1:0] dx_q, dy_q, dz_q, dx_d, dy_d, dz_d;
  logic [9:0]    k_q, k_d;
  logic          hit_q, hit_d, val_q, val_d;
  logic [XW-1:0] ex_q, cx_q;
  logic [YW-1:0] ey_q, cy_q;
  logic [ZW-1:0] ez_q, cz_q;
  logic [XW-1:0] cx_d;
  logic [YW-1:0] cy_d;
  logic [ZW-1:0] cz_d;
  logic          ws_q;
  logic [AW-1:0] wa_q;
  logic          wr_pend_q, wr_pend_d;

  logic        mag_start, mag_done;
  logic [9:0]  mag_ca;
  logic [MagBits-1:0] mag;
  logic        mag_go_q, mag_go_d;

  vrm_mag_unit #(.FRAC_BITS(FRAC_BITS)) u_mag (
    .clk_i, .rst_ni, .start_i(mag_start), .ca_i(mag_ca), .len_i(len_q),
    .done_o(mag_done), .mag_o(mag)
  );

  logic [19:0] sq_in, sq;
  logic [9:0]  sq_op;
  assign sq = {10'd0, sq_op} * {10'd0, sq_op};
  always_comb begin
    case (idx_q)
      2'd0:    sq_op = w_q;
      2'd1:    sq_op = h_q;
      default: sq_op = f_q;
    endcase
    case (idx_q)
      2'd0:    mag_ca = w_q;
      2'd1:    mag_ca = h_q;
      default: mag_ca = f_q;
    endcase
  end
  assign sq_in = sq;

  logic accept;
  assign busy_o = (state_q != StIdle);
  assign accept = start_i && !busy_o;

  // floor of fixed point: arithmetic shift; wrap by mask (power of two sizes)
  logic signed [PW-1:0] fx, fy, fz;
  assign fx = px_q >>> FRAC_BITS;
  assign fy = py_q >>> FRAC_BITS;
  assign fz = pz_q >>> FRAC_BITS;
  assign cx_d = XW'(fx);
  assign cy_d = YW'(fy);
  assign cz_d = ZW'(fz);

  logic [PW-1:0] mag_ext;
  assign mag_ext = PW'(mag);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    idx_d     = idx_q;
    len_d     = len_q;
    px_d = px_q; py_d = py_q; pz_d = pz_q;
    dx_d = dx_q; dy_d = dy_q; dz_d = dz_q;
    k_d       = k_q;
    hit_d     = hit_q;
    val_d     = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = wa_q;
    mem_wd    = ws_q;
    mem_ra    = AW'({cz_q, cy_q, cx_q});
    mag_start = 1'b0;
    mag_go_d  = 1'b0;
    wr_pend_d = 1'b0;
    if (wr_pend_q) mem_we = 1'b1;
    case (state_q)
      StClear: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = 1'b0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == AW'(Depth - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (accept) begin
          if (cmd_i == CmdWrite) begin
            wr_pend_d = ({26'd0, cell_x_i} < 32'(XSize)) &&
                        ({26'd0, cell_y_i} < 32'(YSize)) &&
                        ({26'd0, cell_z_i} < 32'(ZSize));
          end else begin
            idx_d   = 2'd0;
            len_d   = '0;
            state_d = StLen;
          end
        end
      end
      StLen: begin
        len_d = len_q + 21'(sq_in);
        if (idx_q == 2'd2) begin
          idx_d    = 2'd0;
          mag_go_d = 1'b1;
          state_d  = StMag;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StMag: begin
        mag_start = mag_go_q;
        if (!mag_go_q && mag_done) begin
          case (idx_q)
            2'd0:    dx_d = wneg_q ? -$signed(mag_ext) : $signed(mag_ext);
            2'd1:    dy_d = hneg_q ? -$signed(mag_ext) : $signed(mag_ext);
            default: dz_d = $signed(mag_ext);
          endcase
          if (idx_q == 2'd2) begin
            px_d    = $signed(PW'({eye_x_q, FRAC_BITS'(0)}));
            py_d    = $signed(PW'({eye_y_q, FRAC_BITS'(0)}));
            pz_d    = $signed(PW'({eye_z_q, FRAC_BITS'(0)}));
            k_d     = '0;
            hit_d   = 1'b0;
            state_d = StMarch;
          end else begin
            idx_d    = idx_q + 1'b1;
            mag_go_d = 1'b1;
          end
        end
      end
      StMarch: begin
        if (k_q == steps_q) begin
          state_d = StDone;
        end else begin
          px_d    = px_q + dx_q;
          py_d    = py_q + dy_q;
          pz_d    = pz_q + dz_q;
          k_d     = k_q + 1'b1;
          state_d = StRead;
        end
      end
      StRead: state_d = StTest;
      StTest: begin
        if (mem_rd_q && !(cx_q == ex_q && cy_q == ey_q && cz_q == ez_q)) begin
          hit_d   = 1'b1;
          state_d = StDone;
        end else begin
          state_d = StMarch;
        end
      end
      StDone: begin
        val_d   = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_q     <= '0;
      val_q     <= 1'b0;
      wr_pend_q <= 1'b0;
      mag_go_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      val_q     <= val_d;
      wr_pend_q <= wr_pend_d;
      mag_go_q  <= mag_go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    len_q <= len_d;
    px_q <= px_d; py_q <= py_d; pz_q <= pz_d;
    dx_q <= dx_d; dy_q <= dy_d; dz_q <= dz_d;
    k_q   <= k_d;
    hit_q <= hit_d;
    if (state_q == StMarch) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      cz_q <= cz_d;
    end
    if (accept) begin
      w_q    <= pix_w_i[9] ? 10'(-pix_w_i) : pix_w_i;
      h_q    <= pix_h_i[9] ? 10'(-pix_h_i) : pix_h_i;
      f_q    <= focal_q;
      wneg_q <= pix_w_i[9];
      hneg_q <= pix_h_i[9];
      ws_q   <= solid_i;
      wa_q   <= AW'({cell_z_i[ZW-1:0], cell_y_i[YW-1:0], cell_x_i[XW-1:0]});
      ex_q   <= XW'(eye_x_q);
      ey_q   <= YW'(eye_y_q);
      ez_q   <= ZW'(eye_z_q);
    end
  end

  assign valid_o = val_q;
  assign hit_o   = hit_q;

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == StDone))
    else $error("result without finished cast");
  a_busy_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> busy_o)
    else $error("idle during clear");
  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> (k_q != 10'd0))
    else $error("read without step");
endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the voxel ray march hit test unit.
`timescale 1ns / 1ps
module tb;
  import vrm_pkg::*;

  localparam int unsigned GridDim = 64;
  localparam int unsigned FracBits = 16;
  localparam int unsigned StallLimit = 1200000;

  typedef struct {
    logic              cmd;
    logic [5:0]        x;
    logic [5:0]        y;
    logic [5:0]        z;
    logic              solid;
    logic signed [9:0] w;
    logic signed [9:0] h;
  } voxel_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic valid_o;
  logic hit_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAw-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  voxel_item_t cur_item = '{cmd: CmdWrite, default: '0};
  voxel_item_t pending_items[$];
  bit hit_expect_q[$];
  bit occupancy[GridDim*GridDim*GridDim];
  logic [5:0] eye_x = 6'd10, eye_y = 6'd10, eye_z = 6'd10;
  logic [9:0] focal = 10'd100, steps = 10'd250;
  bit no_idle = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned failures = 0;

  voxel_ray_march_hit_test_unit dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .cmd_i(cur_item.cmd), .cell_x_i(cur_item.x), .cell_y_i(cur_item.y),
    .cell_z_i(cur_item.z), .solid_i(cur_item.solid),
    .pix_w_i(cur_item.w), .pix_h_i(cur_item.h),
    .valid_o, .hit_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint unsigned step_size(longint unsigned comp, longint unsigned len);
    logic [127:0] bound;
    logic [127:0] lhs;
    longint unsigned m;
    longint unsigned t;
    m = 0;
    if (len == 0) return 0;
    bound = 128'(comp * comp) << (2 * FracBits);
    for (int b = MagBits - 1; b >= 0; b--) begin
      t = m | (64'd1 << b);
      lhs = 128'(t * t) * 128'(100 * len);
      if (lhs <= bound) m = t;
    end
    return m;
  endfunction

  function automatic int unsigned cell_of(longint signed p);
    return int'((p >>> FracBits) & (GridDim - 1));
  endfunction

  function automatic bit cast_hits(logic signed [9:0] w, logic signed [9:0] h);
    longint signed wv, hv, fv, dx, dy, dz, rx, ry, rz;
    longint unsigned len;
    int unsigned cx, cy, cz;
    bit hit;
    wv = w;
    hv = h;
    fv = focal;
    hit = 1'b0;
    len = wv * wv + hv * hv + fv * fv;
    dx = step_size(wv < 0 ? -wv : wv, len);
    dy = step_size(hv < 0 ? -hv : hv, len);
    dz = step_size(fv, len);
    if (wv < 0) dx = -dx;
    if (hv < 0) dy = -dy;
    rx = longint'(eye_x) << FracBits;
    ry = longint'(eye_y) << FracBits;
    rz = longint'(eye_z) << FracBits;
    for (int k = 0; k < steps && !hit; k++) begin
      cx = cell_of(rx);
      cy = cell_of(ry);
      cz = cell_of(rz);
      if (!(cx == eye_x && cy == eye_y && cz == eye_z) &&
          occupancy[cx + GridDim * (cy + GridDim * cz)]) hit = 1'b1;
      rx += dx;
      ry += dy;
      rz += dz;
    end
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : driver
    bit fire;
    bit go;
    int unsigned g;
    if (!rst_ni) begin
      start_i <= 1'b0;
      gap_left <= 0;
    end else begin
      fire = start_i && !busy_o;
      g = gap_left;
      go = 1'b1;
      if (fire) begin
        if (cur_item.cmd == CmdWrite)
          occupancy[cur_item.x + GridDim * (cur_item.y + GridDim * cur_item.z)] = cur_item.solid;
        else
          hit_expect_q.push_back(cast_hits(cur_item.w, cur_item.h));
        g = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (fire || !start_i) begin
        go = 1'b0;
        if (g != 0) begin
          g--;
        end else if (pending_items.size() > 0) begin
          cur_item <= pending_items.pop_front();
          go = 1'b1;
        end
      end
      start_i <= go;
      gap_left <= g;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (hit_expect_q.size() == 0) begin
        $error("unexpected result: hit actual %0d", hit_o);
        failures++;
      end else if (hit_o !== hit_expect_q[0]) begin
        $error("hit mismatch: expected %0d actual %0d", hit_expect_q[0], hit_o);
        failures++;
        void'(hit_expect_q.pop_front());
      end else begin
        void'(hit_expect_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o || (psel && penable)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CfgAw'(idx) << 2;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegEyeX:  eye_x = value[5:0];
      RegEyeY:  eye_y = value[5:0];
      RegEyeZ:  eye_z = value[5:0];
      RegFocal: focal = value[9:0];
      RegSteps: steps = value[9:0];
      default: ;
    endcase
  endtask

  task automatic set_view(int ex, int ey, int ez, int f, int s);
    write_reg(RegEyeX, ex);
    write_reg(RegEyeY, ey);
    write_reg(RegEyeZ, ez);
    write_reg(RegFocal, f);
    write_reg(RegSteps, s);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || start_i) @(posedge clk_i);
    while (hit_expect_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic add_write(logic [5:0] x, logic [5:0] y, logic [5:0] z, logic s);
    pending_items.push_back('{cmd: CmdWrite, x: x, y: y, z: z, solid: s, w: '0, h: '0});
  endtask

  task automatic add_cast(logic signed [9:0] w, logic signed [9:0] h);
    pending_items.push_back('{cmd: CmdCast, x: 6'($urandom), y: 6'($urandom),
                              z: 6'($urandom), solid: 1'($urandom), w: w, h: h});
  endtask

  task automatic random_phase(int n);
    int r;
    int reach;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      reach = $urandom_range(0, 16) - 8;
      if (r < 4)
        add_write(6'(eye_x + reach), 6'(eye_y + $urandom_range(0, 16) - 8),
                  6'(eye_z + $urandom_range(0, 20) - 4), $urandom_range(0, 3) != 0);
      else if (r == 4)
        add_write(6'($urandom), 6'($urandom), 6'($urandom), 1'($urandom));
      else if (r < 8)
        add_cast(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      else
        add_cast(10'($urandom_range(0, 2 * focal) - focal),
                 10'($urandom_range(0, 2 * focal) - focal));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_view(10, 10, 10, 100, 250);

    add_cast(10'sd0, 10'sd0);
    add_write(6'd10, 6'd10, 6'd20, 1'b1);
    add_write(6'd10, 6'd10, 6'd10, 1'b1);
    add_cast(10'sd0, 10'sd0);
    add_cast(-10'sd512, -10'sd512);
    add_cast(10'sd511, 10'sd511);
    add_cast(-10'sd512, 10'sd511);
    add_write(6'd63, 6'd63, 6'd63, 1'b1);
    add_write(6'd0, 6'd0, 6'd0, 1'b1);
    add_cast(10'sd511, -10'sd512);
    add_write(6'd10, 6'd10, 6'd20, 1'b0);
    add_cast(10'sd0, 10'sd0);
    add_cast(10'sd1, -10'sd1);
    drain();

    set_view(0, 0, 0, 1, 40);
    add_cast(-10'sd512, -10'sd512);
    add_cast(10'sd0, 10'sd0);
    add_cast(10'sd511, 10'sd0);
    drain();
    set_view(63, 63, 63, 1023, 30);
    add_write(6'd63, 6'd63, 6'd0, 1'b1);
    add_cast(10'sd0, 10'sd0);
    add_cast(10'sd511, 10'sd511);
    drain();
    set_view(5, 5, 5, 0, 20);
    add_cast(10'sd0, 10'sd0);
    add_cast(10'sd3, 10'sd0);
    drain();
    write_reg(RegSteps, 0);
    add_cast(10'sd0, 10'sd0);
    add_cast(10'sd7, -10'sd9);
    drain();
    set_view(32, 32, 0, 200, 1023);
    random_phase(20);
    drain();

    for (int p = 0; p < 8; p++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      set_view($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
               $urandom_range(1, 1023), $urandom_range(1, 60));
      random_phase(200);
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (failures == 0 && hit_expect_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
